### design/chordality_test_mcs_defines.svh
// Assertion macros for the chordality test block
`ifndef CHORDALITY_TEST_MCS_DEFINES_SVH
`define CHORDALITY_TEST_MCS_DEFINES_SVH
`ifndef SYNTH
`define CTM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CTM_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CTM_ASSERT(label, clk, rst, prop, msg)
`define CTM_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

### design/ctm_pkg.sv
// Shared constants for the chordality test block
package ctm_pkg;
  localparam int MaxVertices = 32;
  localparam int IdxW = 5;
  localparam int CntW = 6;
  localparam logic [CntW-1:0] VertexCountReset = 6'd32;
endpackage

### design/ctm_adj_mem.sv
// Adjacency row memory, one write and one registered read port
module ctm_adj_mem #(
  parameter int NV = ctm_pkg::MaxVertices,
  parameter int AW = (NV > 1) ? $clog2(NV) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);
  logic [31:0] mem [NV];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

### design/chordality_test_mcs.sv
// Top level: maximum cardinality search chordality test with a step sequencer
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+--------------------
//  config  | vertex_count_we, vertex_count_wdata       | write when we high
//  input   | row_index, row_bits, row_last             | start & !busy
//  result  | vertex, rank, chordal, result_last        | strobe, one cycle
//
// A last row starts a run that symmetrises the rows (a read and a merge a row),
// searches (a scan of all vertices and an update for each pick), checks, and
// then gives one result per vertex; the check ends early when it fails. The
// shared compare takes one vertex a cycle. busy is high for the whole run.
// Reset returns the sequencer to idle and sets the vertex count to 32; rows
// in memory are undefined until written. The receiver cannot stall results.
module chordality_test_mcs #(
  parameter int MAX_VERTICES = ctm_pkg::MaxVertices
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        vertex_count_we,
  input  logic [5:0]  vertex_count_wdata,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  row_index,
  input  logic [31:0] row_bits,
  input  logic        row_last,
  output logic        strobe,
  output logic [4:0]  vertex,
  output logic [4:0]  rank,
  output logic        chordal,
  output logic        result_last
);
  localparam int L  = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int LW = (L > 1) ? $clog2(L) : 1;

  localparam logic [2:0] S_IDLE = 3'd0, S_SYM = 3'd1, S_PICK = 3'd2,
    S_UPD = 3'd3, S_CHK = 3'd4, S_OUT = 3'd5;

  logic [2:0] state;
  logic [5:0] vertex_count;
  logic [LW:0] n;
  logic [LW-1:0] nm1;

  // sequencer registers
  logic [LW-1:0] ctr;       // main walk index
  logic [LW-1:0] sub;       // inner walk index
  logic          rd_wait;   // memory read in flight (in check: build higher set)
  logic [31:0]   nb [L];    // symmetric neighbour rows
  logic [5:0]    wt [L];
  logic [4:0]    vrank [L];
  logic [4:0]    vat [L];
  logic [31:0]   picked;
  logic [LW-1:0] best;
  logic [5:0]    bestw;
  logic          found;
  logic [31:0]   higher;
  logic          flag;

  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [31:0]   mem_rd;

  // effective vertex count: zero counts as one, clip to lanes
  always_comb begin
    if (vertex_count == 6'd0) begin
      n = (LW+1)'(1);
    end else if ({26'd0, vertex_count} > 32'(L)) begin
      n = (LW+1)'(L);
    end else begin
      n = (LW+1)'(vertex_count);
    end
  end
  assign nm1 = LW'(n - (LW+1)'(1));

  logic [31:0] lmask;
  assign lmask = (32'(n) >= 32'd32) ? 32'hFFFF_FFFF
                 : ((32'd1 << n) - 32'd1);

  assign busy   = (state != S_IDLE);
  assign mem_we = start && !busy && (32'(row_index) < 32'(MAX_VERTICES));
  assign mem_wa = AW'(row_index);
  assign mem_ra = AW'(ctr);

  ctm_adj_mem #(.NV(MAX_VERTICES), .AW(AW)) u_mem (
    .clk(clk), .wr_en(mem_we), .wr_addr(mem_wa), .wr_data(row_bits),
    .rd_addr(mem_ra), .rd_data(mem_rd)
  );

  // row read back during symmetrise, masked to the n active lanes
  logic [31:0] rowv;
  assign rowv = mem_rd & lmask;

  logic [4:0] ctr5, sub5, best5;
  assign ctr5  = 5'(ctr);
  assign sub5  = 5'(sub);
  assign best5 = 5'(best);

  // shared unit operands
  logic [31:0] cur_nb, a_nb;
  logic [4:0]  cw;
  assign cw     = vat[ctr];
  assign cur_nb = nb[LW'(cw)];
  assign a_nb   = nb[sub];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      vertex_count <= ctm_pkg::VertexCountReset;
      strobe       <= 1'b0;
      ctr          <= '0;
      sub          <= '0;
      rd_wait      <= 1'b0;
      flag         <= 1'b1;
    end else begin
      strobe <= (state == S_OUT);
      if (vertex_count_we) begin
        vertex_count <= vertex_count_wdata;
      end
      case (state)
        S_IDLE: begin
          if (start && row_last) begin
            state   <= S_SYM;
            ctr     <= '0;
            rd_wait <= 1'b1;
            for (int i = 0; i < L; i++) begin
              nb[i] <= '0;
            end
          end
        end
        // OR each row into its own lane and its transpose, drop diagonal
        S_SYM: begin
          if (rd_wait) begin
            rd_wait <= 1'b0;
          end else begin
            for (int i = 0; i < L; i++) begin
              if (rowv[i] && (LW'(i) != ctr)) begin
                nb[i][ctr5] <= 1'b1;
                nb[ctr][i]  <= 1'b1;
              end
            end
            if (ctr == nm1) begin
              state  <= S_PICK;
              ctr    <= nm1;
              sub    <= '0;
              found  <= 1'b0;
              picked <= '0;
              for (int i = 0; i < L; i++) begin
                wt[i] <= 6'd1;
              end
            end else begin
              ctr     <= ctr + LW'(1);
              rd_wait <= 1'b1;
            end
          end
        end
        // scan for best unpicked vertex, one compare per cycle
        S_PICK: begin
          if (!picked[sub5] && (!found || wt[sub] > bestw)) begin
            best  <= sub;
            bestw <= wt[sub];
            found <= 1'b1;
          end
          if (sub == nm1) begin
            state <= S_UPD;
          end else begin
            sub <= sub + LW'(1);
          end
        end
        // rank the pick and bump unpicked neighbours
        S_UPD: begin
          vrank[best] <= ctr5;
          vat[ctr]    <= best5;
          for (int i = 0; i < L; i++) begin
            if (!picked[i] && nb[best][i]) begin
              wt[i] <= wt[i] + 6'd1;
            end
          end
          wt[best]      <= 6'd0;
          picked[best5] <= 1'b1;
          sub   <= '0;
          found <= 1'b0;
          if (ctr == '0) begin
            state  <= S_CHK;
            flag   <= 1'b1;
            higher <= '0;
            rd_wait <= 1'b1;
          end else begin
            ctr   <= ctr - LW'(1);
            state <= S_PICK;
          end
        end
        // rd_wait: build higher set of vat[ctr]; else test member sub
        S_CHK: begin
          if (rd_wait) begin
            for (int i = 0; i < L; i++) begin
              higher[i] <= cur_nb[i] && (vrank[i] > vrank[LW'(cw)]);
            end
            rd_wait <= 1'b0;
            sub     <= '0;
          end else begin
            if (higher[sub5] && (((higher & ~(32'd1 << sub5)) & ~a_nb) != 32'd0)) begin
              flag  <= 1'b0;
              state <= S_OUT;
              ctr   <= '0;
            end else if (sub == nm1) begin
              if (ctr == nm1) begin
                state <= S_OUT;
                ctr   <= '0;
              end else begin
                ctr     <= ctr + LW'(1);
                rd_wait <= 1'b1;
              end
            end else begin
              sub <= sub + LW'(1);
            end
          end
        end
        S_OUT: begin
          vertex      <= ctr5;
          rank        <= vrank[ctr];
          chordal     <= (ctr == nm1) ? flag : 1'b0;
          result_last <= (ctr == nm1);
          if (ctr == nm1) begin
            state <= S_IDLE;
          end else begin
            ctr <= ctr + LW'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "chordality_test_mcs_defines.svh"
  `CTM_ASSERT(a_last_strobe, clk, rst, (strobe && result_last) |-> (vertex == 5'(nm1)), "last on wrong vertex")
  `CTM_ASSERT(a_idle_after_last, clk, rst, (strobe && result_last) |-> !busy, "busy after last")
  `CTM_ASSERT(a_chordal_only_last, clk, rst, (strobe && !result_last) |-> !chordal, "chordal early")
  `CTM_ASSERT(a_no_strobe_idle, clk, rst, (state == S_IDLE && !$past(busy)) |-> !strobe, "stray strobe")
endmodule
